/* design/roc_pkg.sv */
// Shared types and constants for the rectangle versus circle overlap pipeline.
`default_nettype none

package roc_pkg;

  localparam int ID_BITS = 16;
  localparam int R2_BITS = 30;

  // Register stages inside each unit, counted from the accepting edge
  localparam int TRI_STAGES    = 3;
  localparam int CORNER_STAGES = 4;
  localparam int EDGE_STAGES   = 6;
  localparam int LATENCY       = EDGE_STAGES + 1;

  typedef enum logic [2:0] {
    CAUSE_NONE   = 3'd0,
    CAUSE_TRI1   = 3'd1,
    CAUSE_TRI2   = 3'd2,
    CAUSE_CORNER = 3'd3,
    CAUSE_EDGE   = 3'd4
  } cause_t;

  typedef enum logic [2:0] {
    REG_UL_X = 3'd0,
    REG_UL_Y = 3'd1,
    REG_UR_X = 3'd2,
    REG_UR_Y = 3'd3,
    REG_LR_X = 3'd4,
    REG_LR_Y = 3'd5,
    REG_LL_X = 3'd6,
    REG_LL_Y = 3'd7
  } reg_idx_t;

endpackage

`default_nettype wire

/* design/roc_tri_sign.sv */
// Cross-product sign of (c - q) x (p - q), three register stages.
`default_nettype none

module roc_tri_sign #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic signed [COORD_BITS-1:0] cx,
  input  wire logic signed [COORD_BITS-1:0] cy,
  input  wire logic signed [COORD_BITS-1:0] qx,
  input  wire logic signed [COORD_BITS-1:0] qy,
  input  wire logic signed [COORD_BITS-1:0] px,
  input  wire logic signed [COORD_BITS-1:0] py,
  output logic                              neg
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [DW-1:0] dx, dy, ex, ey;
  logic signed [PW-1:0] lprod, rprod;

  always_ff @(posedge clk) begin
    dx <= DW'(cx) - DW'(qx);
    dy <= DW'(cy) - DW'(qy);
    ex <= DW'(px) - DW'(qx);
    ey <= DW'(py) - DW'(qy);
    lprod <= PW'(dx) * PW'(ey);
    rprod <= PW'(ex) * PW'(dy);
    // difference is negative exactly when the left product is smaller
    neg <= lprod < rprod;
  end

endmodule

`default_nettype wire

/* design/roc_corner.sv */
// Corner-in-circle test: squared distance against squared radius, four stages.
`default_nettype none

module roc_corner #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic signed [COORD_BITS-1:0]        cx,
  input  wire logic signed [COORD_BITS-1:0]        cy,
  input  wire logic signed [COORD_BITS-1:0]        vx,
  input  wire logic signed [COORD_BITS-1:0]        vy,
  input  wire logic        [roc_pkg::R2_BITS-1:0]  r2,
  output logic                                     hit
);

  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * COORD_BITS + 2;
  localparam int CMPW = (PW > roc_pkg::R2_BITS) ? PW : roc_pkg::R2_BITS;

  logic signed [DW-1:0]               dx, dy;
  logic signed [PW-1:0]               sx, sy;
  logic        [PW-1:0]               d2;
  logic        [roc_pkg::R2_BITS-1:0] r2_1, r2_2, r2_3;

  always_ff @(posedge clk) begin
    dx   <= DW'(vx) - DW'(cx);
    dy   <= DW'(vy) - DW'(cy);
    r2_1 <= r2;
    sx   <= PW'(dx) * PW'(dx);
    sy   <= PW'(dy) * PW'(dy);
    r2_2 <= r2_1;
    d2   <= sx + sy;
    r2_3 <= r2_2;
    hit  <= CMPW'(d2) <= CMPW'(r2_3);
  end

endmodule

`default_nettype wire

/* design/roc_edge.sv */
// Edge-within-radius test for segment a to b, six register stages.
`default_nettype none

module roc_edge #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic signed [COORD_BITS-1:0]        cx,
  input  wire logic signed [COORD_BITS-1:0]        cy,
  input  wire logic signed [COORD_BITS-1:0]        ax,
  input  wire logic signed [COORD_BITS-1:0]        ay,
  input  wire logic signed [COORD_BITS-1:0]        bx,
  input  wire logic signed [COORD_BITS-1:0]        by,
  input  wire logic        [roc_pkg::R2_BITS-1:0]  r2,
  output logic                                     hit
);

  localparam int RB = roc_pkg::R2_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = 2 * COORD_BITS + 3;
  localparam int LW = 2 * COORD_BITS + 1;
  localparam int LO = LW / 2;
  localparam int HI = LW - LO;
  localparam int QW = 2 * LW;
  localparam int RW = RB + LW;
  localparam int MW = (QW > RW) ? QW : RW;

  logic signed [DW-1:0] dx, dy, ex, ey;
  logic signed [PW-1:0] p_dxex, p_dyey, p_dxey, p_dyex, p_exex, p_eyey;
  logic signed [PW-1:0] cr_full;
  logic signed [SW-1:0] k;
  logic        [LW-1:0] len2, acr;
  logic                 kpos, klt, span_ok;
  logic [2*HI-1:0]      pp_hh;
  logic [HI+LO-1:0]     pp_hl;
  logic [2*LO-1:0]      pp_ll;
  logic [RB+HI-1:0]     rl_h;
  logic [RB+LO-1:0]     rl_l;
  logic [QW-1:0]        sq;
  logic [RW-1:0]        rl;
  logic [RB-1:0]        r2_1, r2_2, r2_3;

  assign cr_full = p_dxey - p_dyex;

  always_ff @(posedge clk) begin
    // stage 1: offsets from corner a
    dx   <= DW'(cx) - DW'(ax);
    dy   <= DW'(cy) - DW'(ay);
    ex   <= DW'(bx) - DW'(ax);
    ey   <= DW'(by) - DW'(ay);
    r2_1 <= r2;
    // stage 2: products
    p_dxex <= PW'(dx) * PW'(ex);
    p_dyey <= PW'(dy) * PW'(ey);
    p_dxey <= PW'(dx) * PW'(ey);
    p_dyex <= PW'(dy) * PW'(ex);
    p_exex <= PW'(ex) * PW'(ex);
    p_eyey <= PW'(ey) * PW'(ey);
    r2_2   <= r2_1;
    // stage 3: dot product, squared length, magnitude of cross product
    k    <= SW'(p_dxex) + SW'(p_dyey);
    len2 <= LW'(p_exex + p_eyey);
    acr  <= LW'(cr_full[PW-1] ? -cr_full : cr_full);
    r2_3 <= r2_2;
    // stage 4: projection bounds and split partial products
    kpos  <= !k[SW-1] && (k != '0);
    klt   <= k[SW-1] || (k[SW-2:0] < (SW-1)'(len2));
    pp_hh <= (2*HI)'(acr[LW-1:LO]) * (2*HI)'(acr[LW-1:LO]);
    pp_hl <= (HI+LO)'(acr[LW-1:LO]) * (HI+LO)'(acr[LO-1:0]);
    pp_ll <= (2*LO)'(acr[LO-1:0]) * (2*LO)'(acr[LO-1:0]);
    rl_h  <= (RB+HI)'(r2_3) * (RB+HI)'(len2[LW-1:LO]);
    rl_l  <= (RB+LO)'(r2_3) * (RB+LO)'(len2[LO-1:0]);
    // stage 5: recombine partial products
    sq      <= (QW'(pp_hh) << (2*LO)) + (QW'(pp_hl) << (LO+1)) + QW'(pp_ll);
    rl      <= (RW'(rl_h) << LO) + RW'(rl_l);
    span_ok <= kpos && klt;
    // stage 6: distance compare
    hit <= span_ok && (MW'(sq) <= MW'(rl));
  end

endmodule

`default_nettype wire

/* design/rect_circle_overlap_test_unit.sv */
// An accepted start passes the unit stages and then the done and result registers.
// Throughput: one item per cycle; busy is low outside reset, done cannot be held off.
// The edge-distance unit (six stages: offsets, products, sums, split squares,
// recombine, compare) sets the depth; triangle and corner flags are delayed to match.
// Reset (rst, synchronous, active high) clears the corners to zero and empties the pipe.
`default_nettype none

module rect_circle_overlap_test_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [roc_pkg::ID_BITS-1:0]         object_id,
  input  wire logic signed [COORD_BITS-1:0]        center_x,
  input  wire logic signed [COORD_BITS-1:0]        center_y,
  input  wire logic [roc_pkg::R2_BITS-1:0]         radius_squared,
  output logic                                     done,
  output logic [roc_pkg::ID_BITS-1:0]              result_id,
  output logic                                     overlaps,
  output logic [2:0]                               hit_cause,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [2:0]                          cfg_index,
  input  wire logic [COORD_BITS-1:0]               cfg_data
);

  localparam int NS      = roc_pkg::EDGE_STAGES;
  localparam int TRI_DLY = roc_pkg::EDGE_STAGES - roc_pkg::TRI_STAGES;
  localparam int CNR_DLY = roc_pkg::EDGE_STAGES - roc_pkg::CORNER_STAGES;

  logic signed [COORD_BITS-1:0] upper_left_x, upper_left_y, upper_right_x, upper_right_y;
  logic signed [COORD_BITS-1:0] lower_right_x, lower_right_y, lower_left_x, lower_left_y;

  logic                          accept;
  logic [NS-1:0]                 vld;
  logic [roc_pkg::ID_BITS-1:0]   id_dly [NS];
  logic [4:0]                    tri_neg;
  logic [4:0]                    tri_dly [TRI_DLY];
  logic [3:0]                    cnr_hit;
  logic [3:0]                    cnr_dly [CNR_DLY];
  logic [3:0]                    edge_hit;
  logic [4:0]                    tn;
  logic                          in_tri1, in_tri2;
  roc_pkg::cause_t               cause, cause_next;

  assign busy      = rst;
  assign cfg_ready = !rst;
  assign accept    = start && !busy;

  // corner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_left_x  <= '0;
      upper_left_y  <= '0;
      upper_right_x <= '0;
      upper_right_y <= '0;
      lower_right_x <= '0;
      lower_right_y <= '0;
      lower_left_x  <= '0;
      lower_left_y  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (roc_pkg::reg_idx_t'(cfg_index))
        roc_pkg::REG_UL_X: upper_left_x  <= cfg_data;
        roc_pkg::REG_UL_Y: upper_left_y  <= cfg_data;
        roc_pkg::REG_UR_X: upper_right_x <= cfg_data;
        roc_pkg::REG_UR_Y: upper_right_y <= cfg_data;
        roc_pkg::REG_LR_X: lower_right_x <= cfg_data;
        roc_pkg::REG_LR_Y: lower_right_y <= cfg_data;
        roc_pkg::REG_LL_X: lower_left_x  <= cfg_data;
        roc_pkg::REG_LL_Y: lower_left_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  // triangle signs: (q,p) = (ll,ul) (lr,ll) (ul,lr) (ur,ul) (lr,ur)
  roc_tri_sign #(.COORD_BITS(COORD_BITS)) u_tri0 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .qx(lower_left_x), .qy(lower_left_y), .px(upper_left_x), .py(upper_left_y),
    .neg(tri_neg[0])
  );
  roc_tri_sign #(.COORD_BITS(COORD_BITS)) u_tri1 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .qx(lower_right_x), .qy(lower_right_y), .px(lower_left_x), .py(lower_left_y),
    .neg(tri_neg[1])
  );
  roc_tri_sign #(.COORD_BITS(COORD_BITS)) u_tri2 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .qx(upper_left_x), .qy(upper_left_y), .px(lower_right_x), .py(lower_right_y),
    .neg(tri_neg[2])
  );
  roc_tri_sign #(.COORD_BITS(COORD_BITS)) u_tri3 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .qx(upper_right_x), .qy(upper_right_y), .px(upper_left_x), .py(upper_left_y),
    .neg(tri_neg[3])
  );
  roc_tri_sign #(.COORD_BITS(COORD_BITS)) u_tri4 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .qx(lower_right_x), .qy(lower_right_y), .px(upper_right_x), .py(upper_right_y),
    .neg(tri_neg[4])
  );

  roc_corner #(.COORD_BITS(COORD_BITS)) u_cnr0 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .vx(upper_left_x), .vy(upper_left_y), .r2(radius_squared), .hit(cnr_hit[0])
  );
  roc_corner #(.COORD_BITS(COORD_BITS)) u_cnr1 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .vx(lower_left_x), .vy(lower_left_y), .r2(radius_squared), .hit(cnr_hit[1])
  );
  roc_corner #(.COORD_BITS(COORD_BITS)) u_cnr2 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .vx(lower_right_x), .vy(lower_right_y), .r2(radius_squared), .hit(cnr_hit[2])
  );
  roc_corner #(.COORD_BITS(COORD_BITS)) u_cnr3 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .vx(upper_right_x), .vy(upper_right_y), .r2(radius_squared), .hit(cnr_hit[3])
  );

  roc_edge #(.COORD_BITS(COORD_BITS)) u_edge0 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .ax(lower_right_x), .ay(lower_right_y), .bx(upper_right_x), .by(upper_right_y),
    .r2(radius_squared), .hit(edge_hit[0])
  );
  roc_edge #(.COORD_BITS(COORD_BITS)) u_edge1 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .ax(lower_left_x), .ay(lower_left_y), .bx(lower_right_x), .by(lower_right_y),
    .r2(radius_squared), .hit(edge_hit[1])
  );
  roc_edge #(.COORD_BITS(COORD_BITS)) u_edge2 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .ax(upper_left_x), .ay(upper_left_y), .bx(lower_left_x), .by(lower_left_y),
    .r2(radius_squared), .hit(edge_hit[2])
  );
  roc_edge #(.COORD_BITS(COORD_BITS)) u_edge3 (
    .clk(clk), .cx(center_x), .cy(center_y),
    .ax(upper_left_x), .ay(upper_left_y), .bx(upper_right_x), .by(upper_right_y),
    .r2(radius_squared), .hit(edge_hit[3])
  );

  // valid bits and ids advance alongside the unit stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    id_dly[0] <= object_id;
    for (int i = 1; i < NS; i++) begin
      id_dly[i] <= id_dly[i-1];
    end
    tri_dly[0] <= tri_neg;
    for (int i = 1; i < TRI_DLY; i++) begin
      tri_dly[i] <= tri_dly[i-1];
    end
    cnr_dly[0] <= cnr_hit;
    for (int i = 1; i < CNR_DLY; i++) begin
      cnr_dly[i] <= cnr_dly[i-1];
    end
  end

  assign tn      = tri_dly[TRI_DLY-1];
  assign in_tri1 = (tn[0] == tn[1]) && (tn[1] == tn[2]);
  assign in_tri2 = (tn[3] == tn[4]) && (tn[4] == tn[2]);

  // first passing test in priority order gives the cause
  always_comb begin
    if (in_tri1) begin
      cause_next = roc_pkg::CAUSE_TRI1;
    end else if (in_tri2) begin
      cause_next = roc_pkg::CAUSE_TRI2;
    end else if (|cnr_dly[CNR_DLY-1]) begin
      cause_next = roc_pkg::CAUSE_CORNER;
    end else if (|edge_hit) begin
      cause_next = roc_pkg::CAUSE_EDGE;
    end else begin
      cause_next = roc_pkg::CAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    result_id <= id_dly[NS-1];
    cause     <= cause_next;
    overlaps  <= cause_next != roc_pkg::CAUSE_NONE;
  end

  assign hit_cause = cause;

  a_item_completes: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(roc_pkg::LATENCY) done)
    else $error("accepted item did not complete on time");

  a_no_spurious_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, roc_pkg::LATENCY))
    else $error("done without a matching accepted item");

  a_overlap_matches_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> (overlaps == (cause != roc_pkg::CAUSE_NONE)))
    else $error("overlap flag disagrees with hit cause");

endmodule

`default_nettype wire

/* sim/rect_circle_overlap_test_unit_test.sv */
// Self-checking bench for the circle versus quadrilateral overlap unit.
module rect_circle_overlap_test_unit_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int R2_MAX      = 32'h3FFF_FFFF;

  typedef logic signed [127:0] big_t;

  typedef enum logic [1:0] {
    STEP_CIRCLE,
    STEP_CONFIG,
    STEP_DRAIN
  } step_kind_t;

  typedef struct packed {
    step_kind_t          kind;
    logic [15:0]         id;
    logic [15:0]         cx;
    logic [15:0]         cy;
    logic [29:0]         r2;
    roc_pkg::reg_idx_t   index;
    logic [15:0]         data;
  } stim_step_t;

  typedef struct packed {
    logic [15:0]       id;
    logic              hit;
    roc_pkg::cause_t   cause;
  } overlap_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            start = 1'b0;
  logic                            busy;
  logic [roc_pkg::ID_BITS-1:0]     object_id = '0;
  logic signed [15:0]              center_x = '0;
  logic signed [15:0]              center_y = '0;
  logic [roc_pkg::R2_BITS-1:0]     radius_squared = '0;
  logic                            done;
  logic [roc_pkg::ID_BITS-1:0]     result_id;
  logic                            overlaps;
  logic [2:0]                      hit_cause;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [2:0]                      cfg_index = '0;
  logic [15:0]                     cfg_data = '0;

  rect_circle_overlap_test_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .object_id      (object_id),
    .center_x       (center_x),
    .center_y       (center_y),
    .radius_squared (radius_squared),
    .done           (done),
    .result_id      (result_id),
    .overlaps       (overlaps),
    .hit_cause      (hit_cause),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Corner registers as the block should hold them, in register index order
  logic [15:0] corner_regs [8];

  stim_step_t stim_steps [$];
  overlap_t   expected_overlaps [$];

  int circles_queued = 0;
  int circles_sent   = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int burst_left     = 0;
  int gap_left       = 0;

  logic       circle_taken;
  logic       cfg_taken;
  logic       issue_start;
  logic       issue_cfg;
  stim_step_t nxt;
  overlap_t   want;

  // Negative only when strictly below zero; zero joins the non-negative side
  function automatic logic cross_neg(big_t ax, big_t ay, big_t bx, big_t by,
                                     big_t qx, big_t qy);
    return ((ax - qx) * (by - qy) - (bx - qx) * (ay - qy)) < 0;
  endfunction

  function automatic logic in_tri(big_t px, big_t py, big_t ax, big_t ay,
                                  big_t bx, big_t by, big_t dx, big_t dy);
    logic s1, s2, s3;
    s1 = cross_neg(px, py, ax, ay, bx, by);
    s2 = cross_neg(px, py, bx, by, dx, dy);
    s3 = cross_neg(px, py, dx, dy, ax, ay);
    return (s1 == s2) && (s2 == s3);
  endfunction

  function automatic logic corner_hit(big_t px, big_t py, big_t rr, big_t vx, big_t vy);
    return (vx - px) * (vx - px) + (vy - py) * (vy - py) <= rr;
  endfunction

  // Projection strictly inside the edge, then squared distance against radius
  function automatic logic edge_hit(big_t px, big_t py, big_t rr,
                                    big_t ax, big_t ay, big_t bx, big_t by);
    big_t dx, dy, ex, ey, proj, len2, crs;
    dx   = px - ax;
    dy   = py - ay;
    ex   = bx - ax;
    ey   = by - ay;
    proj = dx * ex + dy * ey;
    len2 = ex * ex + ey * ey;
    crs  = dx * ey - dy * ex;
    if (proj <= 0 || proj >= len2) return 1'b0;
    return crs * crs <= rr * len2;
  endfunction

  function automatic overlap_t predict_overlap(input logic [15:0] id,
                                               input logic signed [15:0] x,
                                               input logic signed [15:0] y,
                                               input logic [29:0] r2);
    big_t     px, py, rr, ulx, uly, urx, ury, lrx, lry, llx, lly;
    overlap_t res;
    px  = x;
    py  = y;
    rr  = {98'd0, r2};
    ulx = $signed(corner_regs[roc_pkg::REG_UL_X]);
    uly = $signed(corner_regs[roc_pkg::REG_UL_Y]);
    urx = $signed(corner_regs[roc_pkg::REG_UR_X]);
    ury = $signed(corner_regs[roc_pkg::REG_UR_Y]);
    lrx = $signed(corner_regs[roc_pkg::REG_LR_X]);
    lry = $signed(corner_regs[roc_pkg::REG_LR_Y]);
    llx = $signed(corner_regs[roc_pkg::REG_LL_X]);
    lly = $signed(corner_regs[roc_pkg::REG_LL_Y]);
    res.id = id;
    if (in_tri(px, py, ulx, uly, llx, lly, lrx, lry))
      res.cause = roc_pkg::CAUSE_TRI1;
    else if (in_tri(px, py, ulx, uly, urx, ury, lrx, lry))
      res.cause = roc_pkg::CAUSE_TRI2;
    else if (corner_hit(px, py, rr, ulx, uly) || corner_hit(px, py, rr, llx, lly) ||
             corner_hit(px, py, rr, lrx, lry) || corner_hit(px, py, rr, urx, ury))
      res.cause = roc_pkg::CAUSE_CORNER;
    else if (edge_hit(px, py, rr, lrx, lry, urx, ury) ||
             edge_hit(px, py, rr, llx, lly, lrx, lry) ||
             edge_hit(px, py, rr, ulx, uly, llx, lly) ||
             edge_hit(px, py, rr, ulx, uly, urx, ury))
      res.cause = roc_pkg::CAUSE_EDGE;
    else
      res.cause = roc_pkg::CAUSE_NONE;
    res.hit = (res.cause != roc_pkg::CAUSE_NONE);
    return res;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic add_circle(int id, int x, int y, longint r2);
    stim_step_t s;
    s       = '0;
    s.kind  = STEP_CIRCLE;
    s.id    = id[15:0];
    s.cx    = x[15:0];
    s.cy    = y[15:0];
    s.r2    = (r2 > R2_MAX) ? R2_MAX[29:0] : r2[29:0];
    stim_steps.insert(stim_steps.size(), s);
    circles_queued++;
  endtask

  task automatic add_drain();
    stim_step_t s;
    s      = '0;
    s.kind = STEP_DRAIN;
    stim_steps.insert(stim_steps.size(), s);
  endtask

  // Drain the pipe, then load all eight corner registers
  task automatic set_quad(int ulx, int uly, int urx, int ury,
                          int lrx, int lry, int llx, int lly);
    int         v [8];
    stim_step_t s;
    v = '{ulx, uly, urx, ury, lrx, lry, llx, lly};
    add_drain();
    for (int i = 0; i < 8; i++) begin
      s       = '0;
      s.kind  = STEP_CONFIG;
      s.index = roc_pkg::reg_idx_t'(i);
      s.data  = v[i][15:0];
      stim_steps.insert(stim_steps.size(), s);
    end
  endtask

  // Driver: one item or register write per handshake, bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      cfg_valid <= 1'b0;
      foreach (corner_regs[i]) corner_regs[i] = '0;
    end else begin
      circle_taken = start && !busy;
      cfg_taken    = cfg_valid && cfg_ready;
      if (circle_taken) begin
        expected_overlaps.insert(expected_overlaps.size(),
          predict_overlap(object_id, center_x, center_y, radius_squared));
        circles_sent <= circles_sent + 1;
      end
      if (cfg_taken) corner_regs[cfg_index] = cfg_data;
      if ((start && !circle_taken) || (cfg_valid && !cfg_taken)) begin
        // hold the offered item until it is taken
      end else begin
        issue_start = 1'b0;
        issue_cfg   = 1'b0;
        if (stim_steps.size() != 0 && stim_steps[0].kind == STEP_DRAIN) begin
          if (!circle_taken && results_seen == circles_sent)
            void'(stim_steps.pop_front());
        end else if (stim_steps.size() != 0 && stim_steps[0].kind == STEP_CONFIG) begin
          nxt       = stim_steps.pop_front();
          cfg_index <= nxt.index;
          cfg_data  <= nxt.data;
          issue_cfg = 1'b1;
        end else if (stim_steps.size() != 0) begin
          if (gap_left != 0) begin
            gap_left--;
          end else begin
            nxt            = stim_steps.pop_front();
            object_id      <= nxt.id;
            center_x       <= nxt.cx;
            center_y       <= nxt.cy;
            radius_squared <= nxt.r2;
            issue_start    = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 40);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
          end
        end
        start     <= issue_start;
        cfg_valid <= issue_cfg;
      end
    end
  end

  // Monitor: every done cycle carries one result
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_overlaps.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: id %h overlaps %b cause %0d",
                   result_id, overlaps, hit_cause);
        mismatch_count++;
      end else begin
        want = expected_overlaps.pop_front();
        results_seen <= results_seen + 1;
        if (result_id !== want.id || overlaps !== want.hit || hit_cause !== want.cause) begin
          if (mismatch_count < 10)
            $display({"mismatch: id exp %h got %h, overlaps exp %b got %b,",
                      " cause exp %0d got %0d"},
                     want.id, result_id, want.hit, overlaps, want.cause, hit_cause);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int qx, qy, h, kind, mode, x, y, rd;
    int c [8];
    longint r2;

    // Corners at reset all coincide: every center lands in the first triangle
    add_circle(16'hFFFF, -32768, 32767, R2_MAX);
    add_circle(0, 0, 0, 0);
    add_circle(1, 32767, -32768, 0);

    set_quad(-160, 160, 160, 160, 160, -160, -160, -160);
    add_circle(2, 0, 0, 0);             // center on the shared diagonal
    add_circle(3, -80, -120, 0);
    add_circle(4, 80, 120, 0);
    add_circle(5, 200, 200, 3200);      // corner exactly on the circle
    add_circle(6, 200, 200, 3199);
    add_circle(7, 0, 200, 1600);        // edge exactly at the radius
    add_circle(8, 0, 200, 1599);
    add_circle(9, 200, 0, 1600);
    add_circle(10, 32767, 32767, R2_MAX);
    add_circle(11, 160, 0, 0);          // center on an outer edge

    set_quad(-32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768);
    add_circle(12, -32768, -32768, 0);
    add_circle(13, 32767, 0, 0);
    add_circle(14, 0, 0, R2_MAX);

    // Upper corners coincide, leaving a zero-length top edge
    set_quad(0, 320, 0, 320, 320, 0, -320, 0);
    add_circle(15, 0, 400, 6400);
    add_circle(16, 0, 400, 100);
    add_circle(17, 1000, 1000, 5000);

    // Self-crossing quadrilateral
    set_quad(-200, 200, 200, -200, 200, 200, -200, -200);
    add_circle(18, 0, 100, 0);
    add_circle(19, 0, -100, 0);
    add_circle(20, 300, 0, 10000);

    for (int phase = 0; phase < 10; phase++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        qx = 0;
        qy = 0;
        h  = 16000;
        foreach (c[i]) c[i] = rand16();
      end else if (kind == 1) begin
        qx = jitter(20000);
        qy = jitter(20000);
        h  = 200;
        foreach (c[i]) c[i] = (i % 2 == 0) ? qx : qy;
        if ($urandom_range(0, 1) == 1) begin
          c[roc_pkg::REG_LR_X] = clamp16(qx + jitter(h));
          c[roc_pkg::REG_LR_Y] = clamp16(qy + jitter(h));
        end
      end else begin
        qx = jitter(20000);
        qy = jitter(20000);
        h  = $urandom_range(1, 4000);
        c[roc_pkg::REG_UL_X] = clamp16(qx - h + jitter(h / 2));
        c[roc_pkg::REG_UL_Y] = clamp16(qy + h + jitter(h / 2));
        c[roc_pkg::REG_UR_X] = clamp16(qx + h + jitter(h / 2));
        c[roc_pkg::REG_UR_Y] = clamp16(qy + h + jitter(h / 2));
        c[roc_pkg::REG_LR_X] = clamp16(qx + h + jitter(h / 2));
        c[roc_pkg::REG_LR_Y] = clamp16(qy - h + jitter(h / 2));
        c[roc_pkg::REG_LL_X] = clamp16(qx - h + jitter(h / 2));
        c[roc_pkg::REG_LL_Y] = clamp16(qy - h + jitter(h / 2));
      end
      set_quad(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
      for (int n = 0; n < 100; n++) begin
        if (n == 50 && $urandom_range(0, 1) == 1) add_drain();
        mode = $urandom_range(0, 9);
        if (mode < 8) begin
          x = clamp16(qx + jitter(2 * h + 64));
          y = clamp16(qy + jitter(2 * h + 64));
        end else begin
          x = rand16();
          y = rand16();
        end
        if (mode < 6) begin
          rd = $urandom_range(0, 2 * h + 64);
          r2 = longint'(rd) * rd;
        end else begin
          r2 = $urandom_range(0, R2_MAX);
        end
        add_circle($urandom_range(0, 65535), x, y, r2);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (circles_sent != circles_queued) @(posedge clk);
    while (results_seen != circles_sent) @(posedge clk);
    repeat (roc_pkg::LATENCY + 4) @(posedge clk);
    @(negedge clk);
    if (expected_overlaps.size() != 0) begin
      $display("%0d results never arrived", expected_overlaps.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
design/roc_pkg.sv
design/roc_tri_sign.sv
design/roc_corner.sv
design/roc_edge.sv
design/rect_circle_overlap_test_unit.sv
sim/rect_circle_overlap_test_unit_test.sv
